@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert prop on every rising clock edge outside reset.
`define SDT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("sorted table assertion failed");

// Assert that sig holds its value while cond was true in the prior cycle.
`define SDT_ASSERT_HOLD(lbl, clk, rst_n, cond, sig) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) \
    (cond) |=> $stable(sig)) \
    else $error("sorted table hold assertion failed");

`endif

@@ hw/rtl/sdt_pkg.sv @@
// ----------------------------------------------------------------------------
// sdt_pkg
// Shared widths, operation and status codes, and the cell control word.
// ----------------------------------------------------------------------------
package sdt_pkg;

  localparam int unsigned KIND_W   = 2;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_MISSING = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_BAD     = 2'd3;

  typedef struct packed {
    logic load;
    logic ins;
    logic del;
  } cell_ctrl_t;

endpackage

@@ hw/rtl/sorted_descending_table.sv @@
// ----------------------------------------------------------------------------
// sorted_descending_table
// Bounded table of signed words kept in descending order, duplicates allowed.
//
// The input channel carries one operation word (in_kind_i, in_value_i):
// insert, search, delete first match, or clear. Each accepted word yields one
// result word (out_status_o, out_count_o) on the output channel.
// The table is a row of CAPACITY cells. In the accept cycle every cell
// compares its entry against the broadcast value and registers greater and
// equal flags. In the commit step, which follows unless a held result stalls
// it, the boundary cell is found from neighbor flags, the hit is reduced
// across the row, each cell keeps its entry, takes the new value or loads its
// left or right neighbor's entry, and the result register is written. No new
// word is taken until the last one has committed.
// While a result waits under out_stall_i the next word is still accepted;
// its commit holds until the result register is free.
// Reset empties the table (count zero); entries are not cleared and no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module sorted_descending_table #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [sdt_pkg::KIND_W-1:0]          in_kind_i,
  input  logic signed [sdt_pkg::VALUE_W-1:0]  in_value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [sdt_pkg::STATUS_W-1:0]        out_status_o,
  output logic [sdt_pkg::COUNT_W-1:0]         out_count_o
);
  import sdt_pkg::*;

  localparam int unsigned USED_W = $clog2(CAPACITY + 1);
  localparam logic [USED_W-1:0] CAP_U = USED_W'(CAPACITY);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e                    state_q, state_d;
  logic [USED_W-1:0]         used_q, used_d;
  logic [KIND_W-1:0]         kind_q, kind_d;
  logic signed [VALUE_W-1:0] value_q, value_d;
  logic                      out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]       status_q, status_d;
  logic [COUNT_W-1:0]        count_q, count_d;

  logic                      in_acc;
  logic                      commit;
  logic                      out_fire;
  logic                      hit;
  logic                      full;
  cell_ctrl_t                ctrl;

  logic signed [VALUE_W-1:0] entry_w [CAPACITY];
  logic [CAPACITY-1:0]       gt_w;
  logic [CAPACITY-1:0]       match_w;

  assign in_acc   = in_valid_i && (state_q == ST_IDLE);
  assign commit   = (state_q == ST_EXEC) && !(out_valid_q && out_stall_i);
  assign out_fire = out_valid_q && !out_stall_i;
  assign hit      = |match_w;
  assign full     = (used_q == CAP_U);

  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    kind_d      = kind_q;
    value_d     = value_q;
    out_valid_d = out_fire ? 1'b0 : out_valid_q;
    status_d    = status_q;
    count_d     = count_q;
    ctrl        = '0;
    ctrl.load   = in_acc;
    if (in_acc) begin
      kind_d  = in_kind_i;
      value_d = in_value_i;
      state_d = ST_EXEC;
    end
    if (commit) begin
      state_d     = ST_IDLE;
      out_valid_d = 1'b1;
      status_d    = STATUS_OK;
      case (kind_q)
        KIND_INSERT: begin
          if (full) begin
            status_d = STATUS_FULL;
          end else begin
            ctrl.ins = 1'b1;
            used_d   = used_q + USED_W'(1);
          end
        end
        KIND_SEARCH: begin
          status_d = hit ? STATUS_OK : STATUS_MISSING;
        end
        KIND_DELETE: begin
          if (hit) begin
            ctrl.del = 1'b1;
            used_d   = used_q - USED_W'(1);
          end else begin
            status_d = STATUS_MISSING;
          end
        end
        default: begin
          used_d = '0;
        end
      endcase
      count_d = COUNT_W'(used_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      used_q      <= '0;
      kind_q      <= KIND_INSERT;
      value_q     <= '0;
      out_valid_q <= 1'b0;
      status_q    <= STATUS_OK;
      count_q     <= '0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      kind_q      <= kind_d;
      value_q     <= value_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
      count_q     <= count_d;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                      prev_gt;
    logic signed [VALUE_W-1:0] prev_entry;
    logic signed [VALUE_W-1:0] next_entry;
    logic                      occ;

    if (i == 0) begin : g_first
      assign prev_gt    = 1'b1;
      assign prev_entry = value_q;
    end else begin : g_mid
      assign prev_gt    = gt_w[i-1];
      assign prev_entry = entry_w[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign next_entry = entry_w[i];
    end else begin : g_inner
      assign next_entry = entry_w[i+1];
    end
    assign occ = (used_q > USED_W'(i));

    sdt_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .occ_i        (occ),
      .cmp_value_i  (in_value_i),
      .wr_value_i   (value_q),
      .prev_gt_i    (prev_gt),
      .prev_entry_i (prev_entry),
      .next_entry_i (next_entry),
      .entry_o      (entry_w[i]),
      .gt_o         (gt_w[i]),
      .match_o      (match_w[i])
    );
  end

  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign out_status_o = status_q;
  assign out_count_o  = count_q;

endmodule

@@ hw/rtl/sdt_cell.sv @@
// ----------------------------------------------------------------------------
// sdt_cell
// One table slot: holds an entry, compares it against the broadcast word and
// takes the new word or a neighbor's entry on insert or delete.
// ----------------------------------------------------------------------------
module sdt_cell (
  input  logic                               clk_i,
  input  sdt_pkg::cell_ctrl_t                ctrl_i,
  input  logic                               occ_i,
  input  logic signed [sdt_pkg::VALUE_W-1:0] cmp_value_i,
  input  logic signed [sdt_pkg::VALUE_W-1:0] wr_value_i,
  input  logic                               prev_gt_i,
  input  logic signed [sdt_pkg::VALUE_W-1:0] prev_entry_i,
  input  logic signed [sdt_pkg::VALUE_W-1:0] next_entry_i,
  output logic signed [sdt_pkg::VALUE_W-1:0] entry_o,
  output logic                               gt_o,
  output logic                               match_o
);
  import sdt_pkg::*;

  logic signed [VALUE_W-1:0] entry_q;
  logic                      gt_q;
  logic                      eq_q;
  logic                      boundary;

  assign boundary = prev_gt_i && !gt_q;
  assign entry_o  = entry_q;
  assign gt_o     = gt_q;
  assign match_o  = boundary && eq_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      gt_q <= occ_i && (entry_q > cmp_value_i);
      eq_q <= occ_i && (entry_q == cmp_value_i);
    end
    if (ctrl_i.ins && !gt_q) begin
      entry_q <= boundary ? wr_value_i : prev_entry_i;
    end else if (ctrl_i.del && !gt_q) begin
      entry_q <= next_entry_i;
    end
  end

endmodule

@@ hw/rtl/sdt_checker.sv @@
// ----------------------------------------------------------------------------
// sdt_checker
// Port-level checks on the sorted table, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sdt_checker #(
  parameter int unsigned CAPACITY = 16
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [sdt_pkg::STATUS_W-1:0] out_status_o,
  input logic [sdt_pkg::COUNT_W-1:0]  out_count_o
);
  import sdt_pkg::*;

  logic                         out_held;
  logic                         in_acc;
  logic [STATUS_W+COUNT_W-1:0]  out_word;
  logic                         full_word;
  logic                         full_count;

  assign out_held   = out_valid_o && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_word   = {out_status_o, out_count_o};
  assign full_word  = out_valid_o && (out_status_o == STATUS_FULL);
  assign full_count = (out_count_o == COUNT_W'(CAPACITY));

  `SDT_ASSERT(a_out_valid_hold, clk_i, rst_ni, out_held |=> out_valid_o)
  `SDT_ASSERT_HOLD(a_out_word_hold, clk_i, rst_ni, out_held, out_word)
  `SDT_ASSERT(a_status_code, clk_i, rst_ni, out_valid_o |-> (out_status_o != STATUS_BAD))
  `SDT_ASSERT(a_full_count, clk_i, rst_ni, full_word |-> full_count)
  `SDT_ASSERT(a_busy_after_accept, clk_i, rst_ni, in_acc |=> in_stall_o)

endmodule

bind sorted_descending_table sdt_checker #(
  .CAPACITY (CAPACITY)
) u_sdt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .out_status_o (out_status_o),
  .out_count_o  (out_count_o)
);

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Testbench for sorted_descending_table.
//
// Drives insert, search, delete and clear words through the valid/stall input
// channel and checks every result word (status and count) against a local
// model of the descending table, held in order, or a directed row's fixed
// result. A short table of directed words covers the empty and full table, the
// value extremes, duplicates and absent values. Random words follow, biased
// toward a small pool of values so that searches and deletes hit and the table
// fills and drains. The sender pauses between random bursts, and the receiver
// stalls on its own pattern, once for a long stretch so the block backs up.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sdt_pkg::*;

  localparam int CAPACITY     = 16;
  localparam int RANDOM_WORDS = 1326;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_LIMIT   = 2000;
  localparam int TAIL_CYCLES  = 8;
  localparam int REPORT_MAX   = 10;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
  } table_result_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] value;
    logic               typed;
    table_result_t      want;
  } stim_row_t;

  logic                       clk_i        = 1'b0;
  logic                       rst_ni       = 1'b0;
  logic                       in_valid_i   = 1'b0;
  logic                       in_stall_o;
  logic [KIND_W-1:0]          in_kind_i    = KIND_SEARCH;
  logic signed [VALUE_W-1:0]  in_value_i   = '0;
  logic                       out_valid_o;
  logic                       out_stall_i  = 1'b0;
  logic [STATUS_W-1:0]        out_status_o;
  logic [COUNT_W-1:0]         out_count_o;

  logic signed [VALUE_W-1:0]  table_words [CAPACITY];
  int                         table_used   = 0;
  table_result_t              pending_results [$];
  stim_row_t                  directed_rows [24];
  logic signed [VALUE_W-1:0]  value_pool [8];
  int                         mismatch_count = 0;
  int                         idle_cycles    = 0;
  int                         burst_left     = 0;
  bit                         hold_req       = 1'b0;

  sorted_descending_table #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_kind_i   (in_kind_i),
    .in_value_i  (in_value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_status_o(out_status_o),
    .out_count_o (out_count_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic table_result_t table_apply(input logic [KIND_W-1:0] kind,
                                                input logic signed [VALUE_W-1:0] value);
    table_result_t res;
    int            pos;
    int            hit;
    res.status = STATUS_OK;
    case (kind)
      KIND_INSERT: begin
        if (table_used >= CAPACITY) begin
          res.status = STATUS_FULL;
        end else begin
          pos = 0;
          while (pos < table_used && table_words[pos] > value) pos++;
          for (int j = table_used; j > pos; j--) table_words[j] = table_words[j-1];
          table_words[pos] = value;
          table_used++;
        end
      end
      KIND_SEARCH, KIND_DELETE: begin
        hit = -1;
        for (int i = table_used - 1; i >= 0; i--) begin
          if (table_words[i] == value) hit = i;
        end
        if (hit < 0) begin
          res.status = STATUS_MISSING;
        end else if (kind == KIND_DELETE) begin
          for (int j = hit; j < table_used - 1; j++) table_words[j] = table_words[j+1];
          table_used--;
        end
      end
      default: begin
        table_used = 0;
      end
    endcase
    res.count = COUNT_W'(table_used);
    return res;
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX) $display("mismatch: %s", msg);
  endtask

  task automatic send_word(input logic [KIND_W-1:0] kind,
                           input logic signed [VALUE_W-1:0] value);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_kind_i  <= kind;
    in_value_i <= value;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
  endtask

  initial begin
    int                        span_left;
    int                        pick;
    bit                        fill_mode;
    logic [KIND_W-1:0]         kind;
    logic signed [VALUE_W-1:0] value;
    table_result_t             outcome;

    directed_rows = '{
      '{KIND_SEARCH, 32'h00000000, 1'b1, '{STATUS_MISSING, 5'd0}},
      '{KIND_DELETE, 32'hFFFFFFFB, 1'b1, '{STATUS_MISSING, 5'd0}},
      '{KIND_INSERT, 32'h7FFFFFFF, 1'b1, '{STATUS_OK, 5'd1}},
      '{KIND_INSERT, 32'h80000000, 1'b1, '{STATUS_OK, 5'd2}},
      '{KIND_INSERT, 32'h00000000, 1'b1, '{STATUS_OK, 5'd3}},
      '{KIND_INSERT, 32'h00000000, 1'b1, '{STATUS_OK, 5'd4}},
      '{KIND_INSERT, 32'h00000001, 1'b0, '{STATUS_OK, 5'd0}},
      '{KIND_INSERT, 32'hFFFFFFFF, 1'b0, '{STATUS_OK, 5'd0}},
      '{KIND_INSERT, 32'h7FFFFFFF, 1'b0, '{STATUS_OK, 5'd0}},
      '{KIND_INSERT, 32'h80000000, 1'b0, '{STATUS_OK, 5'd0}},
      '{KIND_INSERT, 32'h00000064, 1'b0, '{STATUS_OK, 5'd0}},
      '{KIND_INSERT, 32'hFFFFFF9C, 1'b0, '{STATUS_OK, 5'd0}},
      '{KIND_INSERT, 32'h5555AAAA, 1'b0, '{STATUS_OK, 5'd0}},
      '{KIND_INSERT, 32'hAAAA5555, 1'b0, '{STATUS_OK, 5'd0}},
      '{KIND_INSERT, 32'h00000001, 1'b0, '{STATUS_OK, 5'd0}},
      '{KIND_INSERT, 32'h7FFFFFFE, 1'b0, '{STATUS_OK, 5'd0}},
      '{KIND_INSERT, 32'h80000001, 1'b0, '{STATUS_OK, 5'd0}},
      '{KIND_INSERT, 32'h0000002A, 1'b1, '{STATUS_OK, 5'd16}},
      '{KIND_INSERT, 32'h00000000, 1'b1, '{STATUS_FULL, 5'd16}},
      '{KIND_SEARCH, 32'h80000000, 1'b0, '{STATUS_OK, 5'd0}},
      '{KIND_DELETE, 32'h00000000, 1'b0, '{STATUS_OK, 5'd0}},
      '{KIND_DELETE, 32'h00012345, 1'b1, '{STATUS_MISSING, 5'd15}},
      '{KIND_SEARCH, 32'h00000000, 1'b0, '{STATUS_OK, 5'd0}},
      '{KIND_CLEAR,  32'hFFFFFFFF, 1'b1, '{STATUS_OK, 5'd0}}
    };
    foreach (value_pool[p]) value_pool[p] = $urandom;
    span_left = 0;
    fill_mode = 1'b1;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[r]) begin
      send_word(directed_rows[r].kind, $signed(directed_rows[r].value));
      outcome = table_apply(directed_rows[r].kind, $signed(directed_rows[r].value));
      pending_results.push_back(directed_rows[r].typed ? directed_rows[r].want : outcome);
    end

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (span_left == 0) begin
        fill_mode = $urandom_range(0, 1);
        span_left = $urandom_range(20, 80);
        value_pool[$urandom_range(0, 7)] = $urandom;
      end
      span_left--;

      pick = $urandom_range(0, 99);
      if (fill_mode) begin
        kind = (pick < 65) ? KIND_INSERT : (pick < 80) ? KIND_SEARCH :
               (pick < 98) ? KIND_DELETE : KIND_CLEAR;
      end else begin
        kind = (pick < 25) ? KIND_INSERT : (pick < 45) ? KIND_SEARCH :
               (pick < 98) ? KIND_DELETE : KIND_CLEAR;
      end

      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        value = value_pool[$urandom_range(0, 7)];
      end else if (pick < 70) begin
        case ($urandom_range(0, 3))
          0:       value = 32'sh7FFFFFFF;
          1:       value = 32'sh80000000;
          2:       value = '0;
          default: value = -1;
        endcase
      end else begin
        value = $urandom;
      end

      if (n == HOLD_AT) hold_req = 1'b1;
      send_word(kind, value);
      pending_results.push_back(table_apply(kind, value));
    end

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // receiver: hold off for a long stretch once, otherwise stall by segment
  initial begin
    int mode;
    int span;
    forever begin
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 60);
      repeat (span) begin
        case (mode)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= ($urandom_range(0, 3) == 0);
          2:       out_stall_i <= $urandom_range(0, 1);
          default: out_stall_i <= ($urandom_range(0, 3) != 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    table_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected word status=%0d count=%0d",
                                out_status_o, out_count_o));
      end else begin
        want = pending_results.pop_front();
        if (out_status_o !== want.status || out_count_o !== want.count) begin
          flag_mismatch($sformatf("status exp=%0d act=%0d, count exp=%0d act=%0d",
                                  want.status, out_status_o, want.count, out_count_o));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/sdt_pkg.sv
hw/rtl/sdt_cell.sv
hw/rtl/sorted_descending_table.sv
hw/rtl/sdt_checker.sv
dv/tb_top.sv
